// ----- hdl/mmstr_pkg.sv -----
// ----------------------------------------------------------------------------
// Modular matrix multiplier package
// Shared types, codes and constants of the modular matrix multiplier.
// ----------------------------------------------------------------------------
package mmstr_pkg;

	localparam int MAX_DIM_DEF   = 16;
	localparam int ELEM_BITS_DEF = 32;
	localparam int SMALL_LIMIT   = 4;
	localparam int DIM_BITS      = 5;
	localparam int IDX_BITS      = 4;

	typedef enum logic [1:0] {
		OP_WRITE_A = 2'd0,
		OP_WRITE_B = 2'd1,
		OP_COMPUTE = 2'd2,
		OP_READ_C  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_MODULUS = 2'd0,
		REG_ROWS    = 2'd1,
		REG_INNER   = 2'd2,
		REG_COLS    = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RED_START,
		ST_RED_WAIT,
		ST_WR_STORE,
		ST_MAC_RD,
		ST_MAC_LOAD,
		ST_RED_A_WAIT,
		ST_MAC_START,
		ST_MAC_WAIT,
		ST_MAC_ACC,
		ST_C_WRITE,
		ST_RD_C,
		ST_RD_OUT,
		ST_OUT_HOLD
	} state_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic in_load;     // Capture the input position and value.
		logic red_start;   // Start reduction of the input value.
		logic store_a;     // Store reduced value in A.
		logic store_b;     // Store reduced value in B.
		logic mac_read;    // Read A and B at current indices.
		logic mac_load;    // Start reduction of the A operand.
		logic mac_start;   // Start modular multiply.
		logic acc_clear;   // Clear the accumulator.
		logic acc_add;     // Add product into accumulator.
		logic c_write;     // Write accumulator into C.
		logic c_read;      // Read C at input position.
		logic out_load;    // Load output register.
	} cmd_t;

	typedef struct packed {
		logic red_done;
		logic mul_done;
	} status_t;

endpackage

// ----- hdl/mmstr_mulmod.sv -----
// ----------------------------------------------------------------------------
// Modular multiply unit
// Bit-serial double-and-add modular multiplication, one bit per cycle.
// ----------------------------------------------------------------------------
module mmstr_mulmod import mmstr_pkg::*; #(
	parameter int ELEM_BITS = ELEM_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [ELEM_BITS-1:0] x,
	input  logic [ELEM_BITS-1:0] y,
	input  logic [ELEM_BITS-1:0] n,
	output logic [ELEM_BITS-1:0] result,
	output logic                 done
);

	localparam int CNT_BITS = $clog2(ELEM_BITS + 1);

	logic [ELEM_BITS-1:0] r_q, x_q, y_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic                 busy_q;
	logic [ELEM_BITS:0]   dbl, dbl_red, add, add_red;

	always_comb begin
		dbl     = {1'b0, r_q} + {1'b0, r_q};
		dbl_red = (dbl >= {1'b0, n}) ? dbl - {1'b0, n} : dbl;
		add     = dbl_red + {1'b0, x_q};
		add_red = (add >= {1'b0, n}) ? add - {1'b0, n} : add;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(ELEM_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= '0;
			x_q <= x;
			y_q <= y;
		end else if (busy_q) begin
			r_q <= y_q[ELEM_BITS-1] ? add_red[ELEM_BITS-1:0] : dbl_red[ELEM_BITS-1:0];
			y_q <= {y_q[ELEM_BITS-2:0], 1'b0};
		end
	end

	assign result = r_q;

endmodule

// ----- hdl/mmstr_datapath.sv -----
// ----------------------------------------------------------------------------
// Modular matrix multiplier datapath
// Element stores, reduction and multiply units, accumulator and output.
// ----------------------------------------------------------------------------
module mmstr_datapath import mmstr_pkg::*; #(
	parameter int MAX_DIM   = MAX_DIM_DEF,
	parameter int ELEM_BITS = ELEM_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output status_t              status,
	input  logic [ELEM_BITS-1:0] n,
	input  logic [IDX_BITS-1:0]  in_row,
	input  logic [IDX_BITS-1:0]  in_col,
	input  logic [ELEM_BITS-1:0] in_value,
	input  logic [IDX_BITS-1:0]  i_idx,
	input  logic [IDX_BITS-1:0]  j_idx,
	input  logic [IDX_BITS-1:0]  l_idx,
	output logic [ELEM_BITS-1:0] out_data
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int ABITS = $clog2(DEPTH);

	logic [ELEM_BITS-1:0] a_mem [DEPTH];
	logic [ELEM_BITS-1:0] b_mem [DEPTH];
	logic [ELEM_BITS-1:0] c_mem [DEPTH];
	logic [ELEM_BITS-1:0] a_rd_q, b_rd_q, c_rd_q, acc_q, red_q;
	logic [ELEM_BITS-1:0] prod, sum_dif;
	logic [ELEM_BITS:0]   sum;
	logic [ABITS-1:0]     in_addr, a_addr, b_addr, c_addr;
	logic                 in_inside;
	logic [IDX_BITS-1:0]  in_row_q, in_col_q;
	logic [ELEM_BITS-1:0] in_value_q;
	logic                 mul_done;

	assign in_inside = (32'(in_row_q) < 32'(MAX_DIM)) && (32'(in_col_q) < 32'(MAX_DIM));
	assign in_addr = ABITS'(32'(in_row_q) * MAX_DIM + 32'(in_col_q));
	assign a_addr  = ABITS'(32'(i_idx) * MAX_DIM + 32'(l_idx));
	assign b_addr  = ABITS'(32'(l_idx) * MAX_DIM + 32'(j_idx));
	assign c_addr  = ABITS'(32'(i_idx) * MAX_DIM + 32'(j_idx));

	// A value is reduced by multiplying one by it, so every bit of the value
	// passes through the modular doubling. The reduced A operand then serves
	// as the multiplicand of the product with B.
	mmstr_mulmod #(.ELEM_BITS(ELEM_BITS)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.red_start | cmd.mac_load | cmd.mac_start),
		.x      (cmd.mac_start ? prod : ELEM_BITS'(1)),
		.y      (cmd.red_start ? in_value_q : (cmd.mac_load ? a_rd_q : b_rd_q)),
		.n      (n),
		.result (prod),
		.done   (mul_done)
	);
	assign status = {mul_done, mul_done};

	always_comb begin
		sum     = {1'b0, acc_q} + {1'b0, prod};
		sum_dif = (sum >= {1'b0, n}) ? ELEM_BITS'(sum - {1'b0, n}) : sum[ELEM_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			in_row_q   <= in_row;
			in_col_q   <= in_col;
			in_value_q <= in_value;
		end
		red_q <= prod;
		if (cmd.store_a && in_inside) a_mem[in_addr] <= red_q;
		if (cmd.store_b && in_inside) b_mem[in_addr] <= red_q;
		if (cmd.c_write) c_mem[c_addr] <= acc_q;
		if (cmd.mac_read) begin
			a_rd_q <= a_mem[a_addr];
			b_rd_q <= b_mem[b_addr];
		end
		if (cmd.c_read) c_rd_q <= c_mem[in_addr];
		if (cmd.acc_clear) acc_q <= '0;
		else if (cmd.acc_add) acc_q <= sum_dif;
		if (cmd.out_load) out_data <= in_inside ? c_rd_q : '0;
	end

endmodule

// ----- hdl/mmstr_ctrl.sv -----
// ----------------------------------------------------------------------------
// Modular matrix multiplier controller
// Sequences writes, the product loops and reads over the datapath.
// ----------------------------------------------------------------------------
module mmstr_ctrl import mmstr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          in_op,
	output logic                out_valid,
	input  logic                out_ready,
	input  logic [DIM_BITS-1:0] dim_a,
	input  logic [DIM_BITS-1:0] dim_b,
	input  logic [DIM_BITS-1:0] dim_c,
	input  status_t             status,
	output cmd_t                cmd,
	output logic [IDX_BITS-1:0] i_idx,
	output logic [IDX_BITS-1:0] j_idx,
	output logic [IDX_BITS-1:0] l_idx
);

	state_t state_q, state_d;
	op_t    op_q;
	logic [IDX_BITS-1:0] i_q, j_q, l_q;
	logic last_l, last_j, last_i;

	assign i_idx = i_q;
	assign j_idx = j_q;
	assign l_idx = l_q;
	assign last_l = ({1'b0, l_q} + 1'b1) >= dim_b;
	assign last_j = ({1'b0, j_q} + 1'b1) >= dim_c;
	assign last_i = ({1'b0, i_q} + 1'b1) >= dim_a;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (op_t'(in_op))
						OP_WRITE_A, OP_WRITE_B: state_d = ST_RED_START;
						OP_COMPUTE:             state_d = ST_MAC_RD;
						default:                state_d = ST_RD_C;
					endcase
				end
			end
			ST_RED_START: state_d = ST_RED_WAIT;
			ST_RED_WAIT:  if (status.red_done) state_d = ST_WR_STORE;
			ST_WR_STORE:  state_d = ST_IDLE;
			ST_MAC_RD:    state_d = ST_MAC_LOAD;
			ST_MAC_LOAD:  state_d = ST_RED_A_WAIT;
			ST_RED_A_WAIT: if (status.red_done) state_d = ST_MAC_START;
			ST_MAC_START: state_d = ST_MAC_WAIT;
			ST_MAC_WAIT:  if (status.mul_done) state_d = ST_MAC_ACC;
			ST_MAC_ACC:   state_d = last_l ? ST_C_WRITE : ST_MAC_RD;
			ST_C_WRITE:   state_d = (last_i && last_j) ? ST_IDLE : ST_MAC_RD;
			ST_RD_C:      state_d = ST_RD_OUT;
			ST_RD_OUT:    state_d = ST_OUT_HOLD;
			ST_OUT_HOLD:  if (out_ready) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.in_load   = 1'b1;
				cmd.acc_clear = 1'b1;
			end
			ST_RED_START: cmd.red_start = 1'b1;
			ST_WR_STORE: begin
				cmd.store_a = (op_q == OP_WRITE_A);
				cmd.store_b = (op_q == OP_WRITE_B);
			end
			ST_MAC_RD:    cmd.mac_read  = 1'b1;
			ST_MAC_LOAD:  cmd.mac_load  = 1'b1;
			ST_MAC_START: cmd.mac_start = 1'b1;
			ST_MAC_ACC:   cmd.acc_add   = 1'b1;
			ST_C_WRITE: begin
				cmd.c_write   = 1'b1;
				cmd.acc_clear = 1'b1;
			end
			ST_RD_C:      cmd.c_read    = 1'b1;
			ST_RD_OUT:    cmd.out_load  = 1'b1;
			ST_OUT_HOLD:  out_valid     = 1'b1;
			default:      cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_WRITE_A;
			i_q     <= '0;
			j_q     <= '0;
			l_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && in_valid) begin
				op_q <= op_t'(in_op);
				i_q  <= '0;
				j_q  <= '0;
				l_q  <= '0;
			end else if (state_q == ST_MAC_ACC) begin
				l_q <= last_l ? '0 : l_q + 1'b1;
			end else if (state_q == ST_C_WRITE) begin
				if (last_j) begin
					j_q <= '0;
					i_q <= i_q + 1'b1;
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
		end
	end

endmodule

// ----- hdl/modular_matrix_multiply_strassen.sv -----
// ----------------------------------------------------------------------------
// Modular matrix multiplier
// Loads A and B element by element and forms C = A*B modulo n.
//
// Items arrive on the s_axis channel: tuser carries the operation, tdata the
// row, column and element value. A write of A or B holds the input while the
// bit-serial modular reduction of the value runs. A compute transfer holds
// the input until all of C is formed: every term first reduces its A operand
// and then multiplies, both on one shared bit-serial unit. A read of C reads
// the element, registers it into the output and presents one transfer on
// m_axis, holding it, blocking new input, until the receiver takes it. Reset
// returns the registers to their defaults (modulus 2, all dimensions 16) and
// leaves the element stores undefined. Configuration is written through
// cfg_we, cfg_index and cfg_data while the block is idle; the user is bound
// to that rule, and the block itself does not enforce it.
// ----------------------------------------------------------------------------
module modular_matrix_multiply_strassen import mmstr_pkg::*; #(
	parameter int MAX_DIM   = MAX_DIM_DEF,
	parameter int ELEM_BITS = ELEM_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // row[3:0], col[7:4], element_value[39:8]
	input  logic [1:0]  s_axis_tuser,  // operation
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata   // product_value
);

	logic [31:0]          modulus_q;
	logic [DIM_BITS-1:0]  rows_q, inner_q, cols_q;
	logic [DIM_BITS-1:0]  dim_a, dim_b, dim_c;
	logic [ELEM_BITS-1:0] n_eff, out_data;
	cmd_t                 cmd;
	status_t              status;
	logic [IDX_BITS-1:0]  i_idx, j_idx, l_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= 32'd2;
			rows_q    <= DIM_BITS'(16);
			inner_q   <= DIM_BITS'(16);
			cols_q    <= DIM_BITS'(16);
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_MODULUS: modulus_q <= cfg_data;
				REG_ROWS:    rows_q    <= cfg_data[DIM_BITS-1:0];
				REG_INNER:   inner_q   <= cfg_data[DIM_BITS-1:0];
				REG_COLS:    cols_q    <= cfg_data[DIM_BITS-1:0];
				default:     modulus_q <= modulus_q;
			endcase
		end
	end

	function automatic logic [DIM_BITS-1:0] clamp(input logic [DIM_BITS-1:0] v);
		if (v == '0) return DIM_BITS'(1);
		if (32'(v) > MAX_DIM) return DIM_BITS'(MAX_DIM);
		return v;
	endfunction

	assign dim_a = clamp(rows_q);
	assign dim_b = clamp(inner_q);
	assign dim_c = clamp(cols_q);
	assign n_eff = (ELEM_BITS'(modulus_q) == '0) ? ELEM_BITS'(1) : ELEM_BITS'(modulus_q);

	mmstr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_op     (s_axis_tuser),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.dim_a     (dim_a),
		.dim_b     (dim_b),
		.dim_c     (dim_c),
		.status    (status),
		.cmd       (cmd),
		.i_idx     (i_idx),
		.j_idx     (j_idx),
		.l_idx     (l_idx)
	);

	mmstr_datapath #(.MAX_DIM(MAX_DIM), .ELEM_BITS(ELEM_BITS)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.n        (n_eff),
		.in_row   (s_axis_tdata[3:0]),
		.in_col   (s_axis_tdata[7:4]),
		.in_value (ELEM_BITS'(s_axis_tdata[39:8])),
		.i_idx    (i_idx),
		.j_idx    (j_idx),
		.l_idx    (l_idx),
		.out_data (out_data)
	);

	assign m_axis_tdata = 32'(out_data);

endmodule
